// ===== rtl/sld_pkg.sv =====
// ----------------------------------------------------------------------------
// sld_pkg: shared types for the sorted list deque engine
// Holds the operation and status codes and the beat structs for both
// directions. The cells and the top level both use these.
// ----------------------------------------------------------------------------
package sld_pkg;

  // Default number of entries the list can hold.
  localparam int unsigned SLD_CAPACITY = 16;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 5;

  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_BACK  = 3'd3,
    MODE_INS_SORT  = 3'd4,
    MODE_REMOVE    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_FULL     = 2'd3
  } status_e;

  // Mode is kept as raw bits so the two unused codes can still arrive.
  typedef struct packed {
    logic [2:0]                   mode;
    logic signed [ValueWidth-1:0] value;
  } item_t;

  typedef struct packed {
    status_e                      status;
    logic [CountWidth-1:0]        count;
    logic signed [ValueWidth-1:0] front_value;
  } result_t;

  // Command broadcast from the top level to every cell.
  typedef struct packed {
    logic                         en;
    logic [2:0]                   mode;
    logic signed [ValueWidth-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/sld_cell.sv =====
// ----------------------------------------------------------------------------
// sld_cell: one position of the list
// Stores one entry and decides each cycle whether to keep it, take the
// neighbor's entry on either side, or load the new value.
// ----------------------------------------------------------------------------
module sld_cell (
  input  logic                                  clk_i,
  input  sld_pkg::cell_cmd_t                    cmd_i,
  input  logic                                  occupied_i,
  input  logic                                  at_fill_i,
  input  logic signed [sld_pkg::ValueWidth-1:0] left_i,
  input  logic signed [sld_pkg::ValueWidth-1:0] right_i,
  input  logic                                  hunt_i,
  output logic                                  hunt_o,
  output logic signed [sld_pkg::ValueWidth-1:0] entry_o,
  output logic signed [sld_pkg::ValueWidth-1:0] entry_next_o
);

  logic signed [sld_pkg::ValueWidth-1:0] entry_q;
  logic signed [sld_pkg::ValueWidth-1:0] entry_d;

  // The hunt chain marks the first position that meets the search rule and
  // every position after it. An empty slot counts as a hit for sorted insert
  // so that a value larger than all entries lands at the back.
  always_comb begin
    case (cmd_i.mode)
      sld_pkg::MODE_INS_SORT: begin
        hunt_o = hunt_i | ~occupied_i | (entry_q >= cmd_i.value);
      end
      sld_pkg::MODE_REMOVE: begin
        hunt_o = hunt_i | (occupied_i & (entry_q == cmd_i.value));
      end
      default: begin
        hunt_o = hunt_i;
      end
    endcase
  end

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.en) begin
      case (cmd_i.mode)
        sld_pkg::MODE_INS_FRONT: begin
          entry_d = left_i;
        end
        sld_pkg::MODE_INS_BACK: begin
          if (at_fill_i) begin
            entry_d = cmd_i.value;
          end
        end
        sld_pkg::MODE_DEL_FRONT: begin
          entry_d = right_i;
        end
        sld_pkg::MODE_INS_SORT: begin
          if (hunt_i) begin
            entry_d = left_i;
          end else if (hunt_o) begin
            entry_d = cmd_i.value;
          end
        end
        sld_pkg::MODE_REMOVE: begin
          // The matching cell and every cell behind it pull from the right.
          if (hunt_o) begin
            entry_d = right_i;
          end
        end
        default: begin
          entry_d = entry_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o      = entry_q;
  assign entry_next_o = entry_d;

endmodule

// ===== rtl/sorted_list_deque_engine_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_deque_engine_core: ordered list with deque and sorted access
// A row of cells holds up to CAPACITY signed entries, front in cell zero.
// ----------------------------------------------------------------------------
// Usage: an input beat (mode and value on item_i) is taken at every rising
// edge where start_i is high and busy_o is low. busy_o is always low, so a
// new beat may be issued in every cycle.
// The result beat (status, count after the operation, front entry or zero
// when empty) appears on result_o in the cycle after the input beat, marked by
// result_valid_o for exactly one cycle. The receiver cannot stall, so the
// result must be captured in that cycle.
// For each beat, in sorted insert and remove, every cell compares its entry
// with the input value in parallel and a one-bit hunt flag ripples down the
// row of cells to find the insert or remove position; each cell then loads
// from its left or right neighbor, or the new value, at the same clock edge.
// Inserts into a full list are dropped with status full; deletes and removes
// on an empty list report empty; a remove without a match reports not found.
// Mode codes six and seven leave the list unchanged and report ok.
// Reset empties the list at once; stale cell contents are never shown.
// ----------------------------------------------------------------------------
module sorted_list_deque_engine_core #(
  parameter int unsigned CAPACITY = sld_pkg::SLD_CAPACITY
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  sld_pkg::item_t   item_i,
  output logic             result_valid_o,
  output sld_pkg::result_t result_o
);

  localparam int unsigned FillWidth = $clog2(CAPACITY + 1);

  logic [FillWidth-1:0] fill_q;
  logic [FillWidth-1:0] fill_d;
  logic                 valid_q;
  logic                 valid_d;
  sld_pkg::result_t     result_q;
  sld_pkg::result_t     result_d;

  logic accept;
  logic is_full;
  logic is_empty;
  logic found;

  sld_pkg::cell_cmd_t cmd;

  logic signed [sld_pkg::ValueWidth-1:0] entry   [CAPACITY];
  logic signed [sld_pkg::ValueWidth-1:0] entry_n [CAPACITY];
  logic        [CAPACITY:0]              hunt;

  // The block never stalls its sender.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign is_full  = (fill_q == FillWidth'(CAPACITY));
  assign is_empty = (fill_q == '0);
  assign found    = hunt[CAPACITY];

  // Decide whether the cells act on this beat and what the list length
  // and status become.
  always_comb begin
    cmd.mode  = item_i.mode;
    cmd.value = item_i.value;
    cmd.en    = 1'b0;
    fill_d    = fill_q;
    result_d.status = sld_pkg::STATUS_OK;
    case (item_i.mode)
      sld_pkg::MODE_INS_FRONT, sld_pkg::MODE_INS_BACK, sld_pkg::MODE_INS_SORT: begin
        if (is_full) begin
          result_d.status = sld_pkg::STATUS_FULL;
        end else begin
          cmd.en = accept;
          fill_d = fill_q + FillWidth'(1);
        end
      end
      sld_pkg::MODE_DEL_FRONT, sld_pkg::MODE_DEL_BACK: begin
        if (is_empty) begin
          result_d.status = sld_pkg::STATUS_EMPTY;
        end else begin
          cmd.en = accept;
          fill_d = fill_q - FillWidth'(1);
        end
      end
      sld_pkg::MODE_REMOVE: begin
        if (is_empty) begin
          result_d.status = sld_pkg::STATUS_EMPTY;
        end else if (!found) begin
          result_d.status = sld_pkg::STATUS_NOTFOUND;
        end else begin
          cmd.en = accept;
          fill_d = fill_q - FillWidth'(1);
        end
      end
      default: begin
        result_d.status = sld_pkg::STATUS_OK;
      end
    endcase
    if (!accept) begin
      fill_d = fill_q;
    end
    valid_d              = accept;
    result_d.count       = sld_pkg::CountWidth'(fill_d);
    result_d.front_value = (fill_d == '0) ? '0 : entry_n[0];
  end

  assign hunt[0] = 1'b0;

  // The row of cells. Cell zero sees the input value as its left neighbor,
  // which serves insert at the front; the last cell sees zero on its right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sld_pkg::ValueWidth-1:0] left;
    logic signed [sld_pkg::ValueWidth-1:0] right;

    if (i == 0) begin : g_first
      assign left = item_i.value;
    end else begin : g_inner_left
      assign left = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_right
      assign right = entry[i+1];
    end

    sld_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (FillWidth'(i) < fill_q),
      .at_fill_i    (FillWidth'(i) == fill_q),
      .left_i       (left),
      .right_i      (right),
      .hunt_i       (hunt[i]),
      .hunt_o       (hunt[i+1]),
      .entry_o      (entry[i]),
      .entry_next_o (entry_n[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      valid_q <= valid_d;
    end
  end

  // Result payload needs no reset; the strobe qualifies it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule
